// ----- rtl/cmdrec_pkg.sv -----
// Shared types, constants and keyword table for the command line recognizer.
package cmdrec_pkg;

  localparam int unsigned LINE_CAPACITY = 128;
  localparam int unsigned FILL_W        = $clog2(LINE_CAPACITY + 1);
  localparam int unsigned ADDR_W        = $clog2(LINE_CAPACITY);

  localparam int unsigned NUM_KW     = 12;
  localparam int unsigned KW_IDX_W   = $clog2(NUM_KW);
  localparam int unsigned KW_MAX_LEN = 10;
  localparam int unsigned BUF_DEPTH  = KW_MAX_LEN + 1;
  localparam int unsigned BUF_IDX_W  = $clog2(BUF_DEPTH);
  localparam int unsigned CNT_W      = $clog2(BUF_DEPTH + 1);

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_NUL   = 8'd0;

  typedef enum logic [1:0] {
    EV_ECHO  = 2'd0,
    EV_ERASE = 2'd1,
    EV_DONE  = 2'd2,
    EV_LONG  = 2'd3
  } event_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MATCH
  } state_e;

  localparam logic [3:0] CMD_UNKNOWN = 4'd0;

  typedef struct packed {
    logic [KW_MAX_LEN-1:0][7:0] text;   // first character in the top byte
    logic [BUF_IDX_W-1:0]       len;
    logic [3:0]                 code;
    logic                       prefix;
  } kw_t;

  function automatic kw_t kw_entry(input logic [KW_IDX_W-1:0] idx);
    kw_t kw;
    kw = '0;
    case (idx)
      4'd0:  kw = '{text: {"help", 48'd0},       len: 4'd4,  code: 4'd1,  prefix: 1'b0};
      4'd1:  kw = '{text: {"hello", 40'd0},      len: 4'd5,  code: 4'd2,  prefix: 1'b0};
      4'd2:  kw = '{text: {"info", 48'd0},       len: 4'd4,  code: 4'd3,  prefix: 1'b0};
      4'd3:  kw = '{text: {"load", 48'd0},       len: 4'd4,  code: 4'd4,  prefix: 1'b0};
      4'd4:  kw = '{text: {"ls", 64'd0},         len: 4'd2,  code: 4'd5,  prefix: 1'b0};
      4'd5:  kw = '{text: {"test", 48'd0},       len: 4'd4,  code: 4'd6,  prefix: 1'b0};
      4'd6:  kw = '{text: {"cat", 56'd0},        len: 4'd3,  code: 4'd7,  prefix: 1'b1};
      4'd7:  kw = '{text: {"exec", 48'd0},       len: 4'd4,  code: 4'd8,  prefix: 1'b1};
      4'd8:  kw = '{text: 80'("setTimeout"),     len: 4'd10, code: 4'd9,  prefix: 1'b1};
      4'd9:  kw = '{text: {"testTask", 16'd0},   len: 4'd8,  code: 4'd10, prefix: 1'b0};
      4'd10: kw = '{text: {"testNest", 16'd0},   len: 4'd8,  code: 4'd11, prefix: 1'b0};
      4'd11: kw = '{text: 80'("testThread"),     len: 4'd10, code: 4'd12, prefix: 1'b0};
      default: kw = '0;
    endcase
    return kw;
  endfunction

endpackage

// ----- rtl/cmdrec_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cmdrec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/command_line_recognizer.sv -----
// Top level of the command line recognizer: line editing and keyword matching.
//
// Input channel (in_valid_i/in_ready_o, rx_byte_i) takes one received byte per
// word. Output channel (out_valid_o/out_ready_i) gives at most one event word
// per input byte: echo, erase, line complete with command code and length, or
// line too long. Bytes of 128 or more are taken and give no word.
// For ordinary bytes, erase and an overlong line end the event is registered and
// shown the cycle after the byte is taken. A line end that is matched copies up
// to eleven stored characters out of the line RAM through its registered read
// port (one per cycle, pipelined) and then runs one keyword per cycle through a
// shared compare unit, stopping at the first hit, and registers the result word.
// The block takes a new byte only while idle and while its output register is
// empty or being emptied, so a stalled receiver holds the input off after one
// pending word. Reset empties the line and the output register; the line RAM
// needs no clearing pass since only characters written since the last line end
// are ever read.
module command_line_recognizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] event_kind_o,
  output logic [7:0] echo_char_o,
  output logic [3:0] command_code_o,
  output logic [7:0] line_length_o
);

  cmdrec_pkg::state_e                    state_q, state_d;
  logic [cmdrec_pkg::FILL_W-1:0]         fill_q, fill_d;
  logic [cmdrec_pkg::CNT_W-1:0]          rd_idx_q, rd_idx_d;
  logic                                  rd_pend_q, rd_pend_d;
  logic [cmdrec_pkg::BUF_IDX_W-1:0]      rd_tag_q, rd_tag_d;
  logic [cmdrec_pkg::CNT_W-1:0]          text_len_q, text_len_d;
  logic [cmdrec_pkg::KW_IDX_W-1:0]       kw_idx_q, kw_idx_d;
  logic [7:0]                            buf_q [cmdrec_pkg::BUF_DEPTH];

  logic                                  out_valid_q, out_valid_d;
  cmdrec_pkg::event_kind_e               kind_q, kind_d;
  logic [7:0]                            echo_q, echo_d;
  logic [3:0]                            code_q, code_d;
  logic [7:0]                            len_q, len_d;

  logic                                  in_fire;
  logic [cmdrec_pkg::CNT_W-1:0]          load_lim;
  logic                                  ram_we, ram_re;
  logic [cmdrec_pkg::ADDR_W-1:0]         ram_raddr;
  logic [7:0]                            ram_rdata;
  logic                                  buf_we;

  cmdrec_pkg::kw_t                       kw;
  logic                                  kw_eq;
  logic [7:0]                            kw_next;
  logic                                  kw_hit;

  cmdrec_ram #(
    .WIDTH (8),
    .DEPTH (cmdrec_pkg::LINE_CAPACITY)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[cmdrec_pkg::ADDR_W-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == cmdrec_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_lim   = (fill_q > cmdrec_pkg::FILL_W'(cmdrec_pkg::BUF_DEPTH)) ?
                      cmdrec_pkg::CNT_W'(cmdrec_pkg::BUF_DEPTH) :
                      cmdrec_pkg::CNT_W'(fill_q);
  assign ram_raddr  = cmdrec_pkg::ADDR_W'(rd_idx_q);

  // Shared compare unit: one keyword against the captured text per cycle.
  always_comb begin
    kw    = cmdrec_pkg::kw_entry(kw_idx_q);
    kw_eq = 1'b1;
    for (int i = 0; i < cmdrec_pkg::KW_MAX_LEN; i++) begin
      if ((cmdrec_pkg::BUF_IDX_W'(i) < kw.len) &&
          (buf_q[i] != kw.text[cmdrec_pkg::KW_MAX_LEN-1-i])) begin
        kw_eq = 1'b0;
      end
    end
    kw_next = buf_q[kw.len];
    kw_hit  = (text_len_q >= cmdrec_pkg::CNT_W'(kw.len)) && kw_eq &&
              ((text_len_q == cmdrec_pkg::CNT_W'(kw.len)) ||
               (kw.prefix && (kw_next == cmdrec_pkg::CH_SPACE)));
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rd_idx_d    = rd_idx_q;
    rd_pend_d   = 1'b0;
    rd_tag_d    = rd_tag_q;
    text_len_d  = text_len_q;
    kw_idx_d    = kw_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    echo_d      = echo_q;
    code_d      = code_q;
    len_d       = len_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    buf_we      = 1'b0;

    case (state_q)
      cmdrec_pkg::ST_IDLE: begin
        if (in_fire && !rx_byte_i[7]) begin
          case (rx_byte_i)
            cmdrec_pkg::CH_BS, cmdrec_pkg::CH_DEL: begin
              if (fill_q != '0) begin
                fill_d = fill_q - 1'b1;
              end
              out_valid_d = 1'b1;
              kind_d      = cmdrec_pkg::EV_ERASE;
              echo_d      = '0;
              code_d      = cmdrec_pkg::CMD_UNKNOWN;
              len_d       = '0;
            end
            cmdrec_pkg::CH_CR, cmdrec_pkg::CH_LF: begin
              if (fill_q == cmdrec_pkg::FILL_W'(cmdrec_pkg::LINE_CAPACITY)) begin
                fill_d      = '0;
                out_valid_d = 1'b1;
                kind_d      = cmdrec_pkg::EV_LONG;
                echo_d      = '0;
                code_d      = cmdrec_pkg::CMD_UNKNOWN;
                len_d       = '0;
              end else begin
                rd_idx_d   = '0;
                text_len_d = load_lim;
                state_d    = cmdrec_pkg::ST_LOAD;
              end
            end
            default: begin
              if (fill_q < cmdrec_pkg::FILL_W'(cmdrec_pkg::LINE_CAPACITY)) begin
                ram_we = 1'b1;
                fill_d = fill_q + 1'b1;
              end
              out_valid_d = 1'b1;
              kind_d      = cmdrec_pkg::EV_ECHO;
              echo_d      = rx_byte_i;
              code_d      = cmdrec_pkg::CMD_UNKNOWN;
              len_d       = '0;
            end
          endcase
        end
      end
      cmdrec_pkg::ST_LOAD: begin
        if (rd_idx_q < load_lim) begin
          ram_re    = 1'b1;
          rd_idx_d  = rd_idx_q + 1'b1;
          rd_pend_d = 1'b1;
          rd_tag_d  = cmdrec_pkg::BUF_IDX_W'(rd_idx_q);
        end
        if (rd_pend_q) begin
          buf_we = 1'b1;
          if ((ram_rdata == cmdrec_pkg::CH_NUL) &&
              (cmdrec_pkg::CNT_W'(rd_tag_q) < text_len_q)) begin
            text_len_d = cmdrec_pkg::CNT_W'(rd_tag_q);
          end
        end
        if ((rd_idx_q == load_lim) && !rd_pend_q) begin
          kw_idx_d = '0;
          state_d  = cmdrec_pkg::ST_MATCH;
        end
      end
      cmdrec_pkg::ST_MATCH: begin
        if (kw_hit || (kw_idx_q == cmdrec_pkg::KW_IDX_W'(cmdrec_pkg::NUM_KW - 1))) begin
          out_valid_d = 1'b1;
          kind_d      = cmdrec_pkg::EV_DONE;
          echo_d      = '0;
          code_d      = kw_hit ? kw.code : cmdrec_pkg::CMD_UNKNOWN;
          len_d       = 8'(fill_q);
          fill_d      = '0;
          state_d     = cmdrec_pkg::ST_IDLE;
        end else begin
          kw_idx_d = kw_idx_q + 1'b1;
        end
      end
      default: begin
        state_d = cmdrec_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cmdrec_pkg::ST_IDLE;
      fill_q      <= '0;
      rd_idx_q    <= '0;
      rd_pend_q   <= 1'b0;
      kw_idx_q    <= '0;
      text_len_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      rd_pend_q   <= rd_pend_d;
      kw_idx_q    <= kw_idx_d;
      text_len_q  <= text_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_tag_q <= rd_tag_d;
    kind_q   <= kind_d;
    echo_q   <= echo_d;
    code_q   <= code_d;
    len_q    <= len_d;
    if (buf_we) begin
      buf_q[rd_tag_q] <= ram_rdata;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = kind_q;
  assign echo_char_o    = echo_q;
  assign command_code_o = code_q;
  assign line_length_o  = len_q;

endmodule
